/* hw/rtl/vmsr_pkg.sv */
// ---------------------------------------------------------------------------
// vmsr_pkg
// MSR numbers, fixed read values, status codes and decode types shared by
// the virtual MSR file and its decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package vmsr_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned CANON_W = 17;

  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_REFUSED = 2'd1,
    ST_FAULT   = 2'd2
  } status_t;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  localparam index_t MSR_APIC_BASE        = 32'h0000_001B;
  localparam index_t MSR_SMI_CNT          = 32'h0000_0034;
  localparam index_t MSR_FEATURE_CONTROL  = 32'h0000_003A;
  localparam index_t MSR_TSC_ADJUST       = 32'h0000_003B;
  localparam index_t MSR_SPEC_CTRL        = 32'h0000_0048;
  localparam index_t MSR_BIOS_SIGN_ID     = 32'h0000_008B;
  localparam index_t MSR_PLAT_INFO        = 32'h0000_00CE;
  localparam index_t MSR_MTRR_CAP         = 32'h0000_00FE;
  localparam index_t MSR_MISC_FEAT_EN     = 32'h0000_0140;
  localparam index_t MSR_SYSENTER_CS      = 32'h0000_0174;
  localparam index_t MSR_SYSENTER_ESP     = 32'h0000_0175;
  localparam index_t MSR_SYSENTER_EIP     = 32'h0000_0176;
  localparam index_t MSR_MISC_ENABLE      = 32'h0000_01A0;
  localparam index_t MSR_MTRR_VAR_FIRST   = 32'h0000_0200;
  localparam index_t MSR_MTRR_VAR_LAST    = 32'h0000_0213;
  localparam index_t MSR_MTRR_FIX64K      = 32'h0000_0250;
  localparam index_t MSR_MTRR_FIX16K_LO   = 32'h0000_0258;
  localparam index_t MSR_MTRR_FIX16K_HI   = 32'h0000_0259;
  localparam index_t MSR_MTRR_FIX4K_FIRST = 32'h0000_0268;
  localparam index_t MSR_MTRR_FIX4K_LAST  = 32'h0000_026F;
  localparam index_t MSR_PAT              = 32'h0000_0277;
  localparam index_t MSR_MTRR_DEF_TYPE    = 32'h0000_02FF;
  localparam index_t MSR_PROD_PERF        = 32'h0000_064E;
  localparam index_t MSR_TSC_DEADLINE     = 32'h0000_06E0;
  localparam index_t MSR_TME_ACTIVATE     = 32'h0000_0982;
  localparam index_t MSR_XSS              = 32'h0000_0DA0;
  localparam index_t MSR_EFER             = 32'hC000_0080;
  localparam index_t MSR_LSTAR            = 32'hC000_0082;

  localparam data_t MISC_ENABLE_VALUE     = 64'h0000_0000_0080_0001;
  localparam data_t APIC_BASE_VALUE       = 64'h0000_0000_FEE0_0900;
  localparam data_t FEATURE_CONTROL_VALUE = 64'h0000_0000_0000_0001;

  localparam logic [CANON_W-1:0] CANON_HIGH_ONES = 17'h1FFFF;

  // architectural state as seen by the decoder
  typedef struct packed {
    data_t syscall_entry_shadow;
    data_t extended_features;
    data_t timer_deadline;
    logic  trampoline_done;
  } state_t;

  // state updates requested for one access
  typedef struct packed {
    logic shadow_we;
    logic efer_we;
    logic deadline_we;
    logic trampoline_set;
  } update_t;

  typedef struct packed {
    data_t   deadline;
    logic    deadline_set;
    logic    install_trampoline;
    status_t status;
    data_t   read_data;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/vmsr_decode.sv */
// ---------------------------------------------------------------------------
// vmsr_decode
// Decodes one MSR access against the current state: gives the result beat
// and the state updates to apply when the access retires.
// ---------------------------------------------------------------------------
`default_nettype none

module vmsr_decode (
  input  var vmsr_pkg::cmd_t    cmd,
  input  var vmsr_pkg::index_t  msr_index,
  input  var vmsr_pkg::data_t   write_data,
  input  var vmsr_pkg::data_t   microcode_revision,
  input  var vmsr_pkg::state_t  state,
  output vmsr_pkg::update_t     update,
  output vmsr_pkg::result_t     result
);

  import vmsr_pkg::*;

  logic canonical;

  assign canonical = (write_data[DATA_W-1:DATA_W-CANON_W] == '0) ||
                     (write_data[DATA_W-1:DATA_W-CANON_W] == CANON_HIGH_ONES);

  always_comb begin
    update                    = '0;
    result.read_data          = '0;
    result.status             = ST_DONE;
    result.install_trampoline = 1'b0;
    result.deadline_set       = 1'b0;

    if (cmd == CMD_READ) begin
      case (msr_index) inside
        MSR_MTRR_CAP, MSR_MTRR_DEF_TYPE, MSR_PAT,
        [MSR_MTRR_VAR_FIRST:MSR_MTRR_VAR_LAST],
        MSR_MTRR_FIX64K, MSR_MTRR_FIX16K_LO, MSR_MTRR_FIX16K_HI,
        [MSR_MTRR_FIX4K_FIRST:MSR_MTRR_FIX4K_LAST],
        MSR_TSC_ADJUST, MSR_PROD_PERF, MSR_SMI_CNT, MSR_MISC_FEAT_EN,
        MSR_PLAT_INFO, MSR_SPEC_CTRL, MSR_TME_ACTIVATE: begin
          result.read_data = '0;
        end
        MSR_LSTAR:           result.read_data = state.syscall_entry_shadow;
        MSR_EFER:            result.read_data = state.extended_features;
        MSR_MISC_ENABLE:     result.read_data = MISC_ENABLE_VALUE;
        MSR_BIOS_SIGN_ID:    result.read_data = microcode_revision;
        MSR_APIC_BASE:       result.read_data = APIC_BASE_VALUE;
        MSR_FEATURE_CONTROL: result.read_data = FEATURE_CONTROL_VALUE;
        default:             result.status    = ST_FAULT;
      endcase
    end else begin
      case (msr_index) inside
        // write-ignore set
        MSR_MTRR_CAP, MSR_MTRR_DEF_TYPE, MSR_PAT,
        [MSR_MTRR_VAR_FIRST:MSR_MTRR_VAR_LAST],
        MSR_MTRR_FIX64K, MSR_MTRR_FIX16K_LO, MSR_MTRR_FIX16K_HI,
        [MSR_MTRR_FIX4K_FIRST:MSR_MTRR_FIX4K_LAST],
        MSR_BIOS_SIGN_ID, MSR_XSS, MSR_MISC_FEAT_EN, MSR_SYSENTER_CS,
        MSR_SYSENTER_ESP, MSR_SYSENTER_EIP, MSR_SPEC_CTRL: begin
          result.status = ST_DONE;
        end
        MSR_LSTAR: begin
          if (!canonical) begin
            result.status = ST_REFUSED;
          end else begin
            update.shadow_we = 1'b1;
            if (!state.trampoline_done) begin
              update.trampoline_set     = 1'b1;
              result.install_trampoline = 1'b1;
            end
          end
        end
        MSR_EFER: update.efer_we = 1'b1;
        MSR_TSC_DEADLINE: begin
          update.deadline_we  = 1'b1;
          result.deadline_set = 1'b1;
        end
        default: result.status = ST_FAULT;
      endcase
    end

    // deadline reported is the value after this access
    result.deadline = update.deadline_we ? write_data : state.timer_deadline;
  end

endmodule

`default_nettype wire

/* hw/rtl/virtual_msr_file.sv */
// ---------------------------------------------------------------------------
// virtual_msr_file
// Emulated MSR file of one virtual x86-64 CPU: one read or write access per
// input beat, one result beat per access.
// ---------------------------------------------------------------------------
//
//  channel   direction  tdata / tuser contents (low bit first)
//  s_axis    in         tuser: cmd[0]; tdata: msr_index[31:0], write_data[95:32]
//  m_axis    out        tdata: read_data[63:0], status[65:64],
//                       install_trampoline[66], deadline_set[67],
//                       deadline[131:68], zero pad[135:132]
//  cfg       in         cfg_we / cfg_wdata: microcode_revision
//
//  Two register stages: an input register, then decode and state update into
//  the result register. m_axis_tvalid rises as the access leaves the input
//  register; one access per cycle is sustained when m_axis_tready stays high.
//  State is updated as an access moves into the result register, so each
//  access sees the effect of every earlier one.
//  A stall on m_axis holds both stages; s_axis_tready drops when the input
//  register is full and cannot advance.
//  rst clears the valid flags, stored MSRs and the microcode revision.
// ---------------------------------------------------------------------------
`default_nettype none

module virtual_msr_file (
  input  wire          clk,
  input  wire          rst,
  // config
  input  wire          cfg_we,
  input  wire  [63:0]  cfg_wdata,
  // access stream
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [95:0]  s_axis_tdata,   // msr_index[31:0], write_data[95:32]
  input  wire  [0:0]   s_axis_tuser,   // cmd[0]
  // result stream
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [135:0] m_axis_tdata    // read_data, status, install_trampoline,
                                       // deadline_set, deadline, zero pad
);

  import vmsr_pkg::*;

  localparam int unsigned RES_W = $bits(result_t);

  data_t   microcode_revision;
  state_t  state;

  logic    in_valid;
  cmd_t    in_cmd;
  index_t  in_index;
  data_t   in_data;

  logic    out_valid;
  result_t out_result;

  logic    advance;
  update_t update;
  result_t result;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      microcode_revision <= '0;
    end else if (cfg_we) begin
      microcode_revision <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd   <= cmd_t'(s_axis_tuser[0]);
      in_index <= s_axis_tdata[INDEX_W-1:0];
      in_data  <= s_axis_tdata[INDEX_W+DATA_W-1:INDEX_W];
    end
  end

  vmsr_decode u_decode (
    .cmd                (in_cmd),
    .msr_index          (in_index),
    .write_data         (in_data),
    .microcode_revision (microcode_revision),
    .state              (state),
    .update             (update),
    .result             (result)
  );

  // architectural state, updated when the access retires into the result reg
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      if (update.shadow_we)      state.syscall_entry_shadow <= in_data;
      if (update.efer_we)        state.extended_features    <= in_data;
      if (update.deadline_we)    state.timer_deadline       <= in_data;
      if (update.trampoline_set) state.trampoline_done      <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(136-RES_W){1'b0}}, out_result};

endmodule

`default_nettype wire

/* test/msr_result_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// msr_result_checker
// Watches the access, result and config channels of the virtual MSR file.
// It keeps its own copy of the MSR state, predicts one result per accepted
// access and compares every result beat field by field, oldest first.
// ---------------------------------------------------------------------------
module msr_result_checker (
  input  wire          clk,
  input  wire          rst,
  input  wire          cfg_we,
  input  wire  [63:0]  cfg_wdata,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [95:0]  s_axis_tdata,   // msr_index[31:0], write_data[95:32]
  input  wire  [0:0]   s_axis_tuser,   // cmd[0]
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  input  wire  [135:0] m_axis_tdata,   // read_data, status, install_trampoline,
                                       // deadline_set, deadline, zero pad
  output int           fail_count,
  output int           outstanding
);

  import vmsr_pkg::*;

  data_t   entry_shadow;
  data_t   efer_value;
  data_t   tsc_deadline;
  data_t   microcode_value;
  logic    trampoline_installed;
  result_t results_due[$];
  result_t got_result;
  result_t want_result;
  int      mismatches;

  function automatic logic is_mtrr_class(index_t idx);
    return idx == MSR_MTRR_CAP || idx == MSR_MTRR_DEF_TYPE || idx == MSR_PAT ||
           (idx >= MSR_MTRR_VAR_FIRST && idx <= MSR_MTRR_VAR_LAST) ||
           idx == MSR_MTRR_FIX64K || idx == MSR_MTRR_FIX16K_LO ||
           idx == MSR_MTRR_FIX16K_HI ||
           (idx >= MSR_MTRR_FIX4K_FIRST && idx <= MSR_MTRR_FIX4K_LAST);
  endfunction

  // applies one access to the shadow state and returns the result it gives
  function automatic result_t predict_access(cmd_t cmd, index_t idx, data_t wdata);
    result_t r;
    r = '0;
    r.status = ST_DONE;
    if (cmd == CMD_READ) begin
      if (!is_mtrr_class(idx)) begin
        case (idx)
          MSR_LSTAR:           r.read_data = entry_shadow;
          MSR_EFER:            r.read_data = efer_value;
          MSR_MISC_ENABLE:     r.read_data = MISC_ENABLE_VALUE;
          MSR_BIOS_SIGN_ID:    r.read_data = microcode_value;
          MSR_APIC_BASE:       r.read_data = APIC_BASE_VALUE;
          MSR_FEATURE_CONTROL: r.read_data = FEATURE_CONTROL_VALUE;
          MSR_TSC_ADJUST, MSR_PROD_PERF, MSR_SMI_CNT, MSR_MISC_FEAT_EN,
          MSR_PLAT_INFO, MSR_SPEC_CTRL, MSR_TME_ACTIVATE: r.read_data = '0;
          default:             r.status = ST_FAULT;
        endcase
      end
    end else if (!is_mtrr_class(idx)) begin
      case (idx)
        MSR_LSTAR: begin
          // bits 63:47 must all match for a 48-bit canonical address
          if (wdata[63:47] != '0 && wdata[63:47] != CANON_HIGH_ONES) begin
            r.status = ST_REFUSED;
          end else begin
            entry_shadow = wdata;
            if (!trampoline_installed) begin
              trampoline_installed = 1'b1;
              r.install_trampoline = 1'b1;
            end
          end
        end
        MSR_EFER: efer_value = wdata;
        MSR_TSC_DEADLINE: begin
          tsc_deadline = wdata;
          r.deadline_set = 1'b1;
        end
        MSR_BIOS_SIGN_ID, MSR_XSS, MSR_MISC_FEAT_EN, MSR_SYSENTER_CS,
        MSR_SYSENTER_ESP, MSR_SYSENTER_EIP, MSR_SPEC_CTRL: ;
        default: r.status = ST_FAULT;
      endcase
    end
    r.deadline = tsc_deadline;
    return r;
  endfunction

  task automatic check_field(string name, data_t want, data_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      entry_shadow         = '0;
      efer_value           = '0;
      tsc_deadline         = '0;
      microcode_value      = '0;
      trampoline_installed = 1'b0;
      mismatches           = 0;
      results_due.delete();
    end else begin
      if (cfg_we) microcode_value = cfg_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        got_result = result_t'(m_axis_tdata[131:0]);
        if (results_due.size() == 0) begin
          $error("result beat with no access outstanding");
          mismatches++;
        end else begin
          want_result = results_due.pop_front();
          check_field("read_data", want_result.read_data, got_result.read_data);
          check_field("status", data_t'(want_result.status), data_t'(got_result.status));
          check_field("install_trampoline", data_t'(want_result.install_trampoline),
                      data_t'(got_result.install_trampoline));
          check_field("deadline_set", data_t'(want_result.deadline_set),
                      data_t'(got_result.deadline_set));
          check_field("deadline", want_result.deadline, got_result.deadline);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        results_due.push_back(predict_access(cmd_t'(s_axis_tuser[0]),
                                             s_axis_tdata[31:0], s_axis_tdata[95:32]));
    end
    fail_count  <= mismatches;
    outstanding <= results_due.size();
  end

endmodule

/* test/tb_virtual_msr_file.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_virtual_msr_file
// Drives MSR reads and writes into the virtual MSR file: a directed pass over
// each decoded class and the LSTAR canonical corners, then three random
// phases with different back-pressure and microcode settings. The checker
// beside the block predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_virtual_msr_file;

  import vmsr_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int NUM_KNOWN   = 28;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [63:0]  cfg_wdata;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata;
  logic [0:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  int src_idle_pct;
  int dst_idle_pct;
  int quiet_cycles;

  index_t known_msrs [NUM_KNOWN] = '{
    MSR_APIC_BASE, MSR_SMI_CNT, MSR_FEATURE_CONTROL, MSR_TSC_ADJUST,
    MSR_SPEC_CTRL, MSR_BIOS_SIGN_ID, MSR_PLAT_INFO, MSR_MTRR_CAP,
    MSR_MISC_FEAT_EN, MSR_SYSENTER_CS, MSR_SYSENTER_ESP, MSR_SYSENTER_EIP,
    MSR_MISC_ENABLE, MSR_MTRR_VAR_FIRST, MSR_MTRR_VAR_LAST, MSR_MTRR_FIX64K,
    MSR_MTRR_FIX16K_LO, MSR_MTRR_FIX16K_HI, MSR_MTRR_FIX4K_FIRST,
    MSR_MTRR_FIX4K_LAST, MSR_PAT, MSR_MTRR_DEF_TYPE, MSR_PROD_PERF,
    MSR_TSC_DEADLINE, MSR_TME_ACTIVATE, MSR_XSS, MSR_EFER, MSR_LSTAR
  };

  virtual_msr_file dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  msr_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= dst_idle_pct);
  end

  // ends the run when no beat of any kind moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_access(cmd_t cmd, index_t idx, data_t wdata);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, idx};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_microcode(data_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_access(output cmd_t cmd, output index_t idx, output data_t wdata);
    int     pick;
    index_t base;
    pick  = $urandom_range(0, 99);
    base  = known_msrs[$urandom_range(0, NUM_KNOWN - 1)];
    cmd   = cmd_t'($urandom_range(0, 1));
    if (pick < 55)
      idx = base;
    else if (pick < 65)
      idx = ($urandom_range(0, 1) != 0) ? MSR_LSTAR :
            (($urandom_range(0, 1) != 0) ? MSR_EFER : MSR_TSC_DEADLINE);
    else if (pick < 70)
      idx = MSR_MTRR_VAR_FIRST + $urandom_range(0, MSR_MTRR_VAR_LAST - MSR_MTRR_VAR_FIRST);
    else if (pick < 75)
      idx = MSR_MTRR_FIX4K_FIRST +
            $urandom_range(0, MSR_MTRR_FIX4K_LAST - MSR_MTRR_FIX4K_FIRST);
    else if (pick < 88)
      idx = ($urandom_range(0, 1) != 0) ? base + 1 : base - 1;
    else
      idx = $urandom;
    wdata = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       wdata = '0;
      1:       wdata = '1;
      2, 3:    wdata[63:47] = '0;
      4, 5:    wdata[63:47] = CANON_HIGH_ONES;
      6:       wdata = ($urandom_range(0, 1) != 0) ? 64'h0000_8000_0000_0000
                                                   : 64'hFFFF_7FFF_FFFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic run_random(int count, int src_pct, int dst_pct);
    cmd_t   cmd;
    index_t idx;
    data_t  wdata;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    for (int i = 0; i < count; i++) begin
      // hold off once mid-phase until the pipeline is empty
      if (i == count / 2) drain_results();
      random_access(cmd, idx, wdata);
      send_access(cmd, idx, wdata);
    end
    drain_results();
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    src_idle_pct  = 0;
    dst_idle_pct  = 0;
    quiet_cycles  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset values, canonical corners, every decoded class
    src_idle_pct = 33;
    dst_idle_pct = 63;
    send_access(CMD_READ,  MSR_BIOS_SIGN_ID, '0);
    send_access(CMD_READ,  MSR_LSTAR, '0);
    send_access(CMD_WRITE, MSR_LSTAR, 64'h0000_8000_0000_0000);
    send_access(CMD_WRITE, MSR_LSTAR, 64'hFFFF_8000_0000_0000);
    send_access(CMD_WRITE, MSR_LSTAR, 64'h0000_7FFF_FFFF_FFFF);
    send_access(CMD_READ,  MSR_LSTAR, '1);
    send_access(CMD_WRITE, MSR_LSTAR, 64'h8000_0000_0000_0000);
    send_access(CMD_WRITE, MSR_EFER, '1);
    send_access(CMD_READ,  MSR_EFER, '0);
    send_access(CMD_WRITE, MSR_TSC_DEADLINE, '1);
    send_access(CMD_READ,  MSR_TSC_DEADLINE, '0);
    send_access(CMD_WRITE, MSR_TSC_DEADLINE, '0);
    send_access(CMD_READ,  MSR_MISC_ENABLE, '0);
    send_access(CMD_READ,  MSR_APIC_BASE, '0);
    send_access(CMD_WRITE, MSR_APIC_BASE, '1);
    send_access(CMD_READ,  MSR_FEATURE_CONTROL, '0);
    send_access(CMD_READ,  MSR_MTRR_VAR_LAST, '0);
    send_access(CMD_WRITE, MSR_PAT, '1);
    send_access(CMD_READ,  MSR_PAT, '0);
    send_access(CMD_WRITE, MSR_XSS, '1);
    send_access(CMD_READ,  MSR_XSS, '0);
    send_access(CMD_WRITE, MSR_BIOS_SIGN_ID, '1);
    send_access(CMD_READ,  32'hFFFF_FFFF, '0);
    send_access(CMD_WRITE, 32'h0000_0000, '1);
    drain_results();

    write_microcode('1);
    send_access(CMD_READ, MSR_BIOS_SIGN_ID, '0);
    run_random(400, 33, 63);
    write_microcode({$urandom, $urandom});
    run_random(300, 63, 33);
    write_microcode('0);
    run_random(300, 0, 0);

    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
